// ----- design/sptab_pkg.sv -----
// ----------------------------------------------------------------------------
// sptab_pkg
// Types and constants for the sorted native-pc side table.
// ----------------------------------------------------------------------------
package sptab_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_APPEND    = 2'd1,
    OP_LOOKUP_PC = 2'd2,
    OP_LOOKUP_OSR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_BSEARCH,
    FSM_SCAN
  } fsm_e;

  typedef struct packed {
    logic [WORD_W-1:0] native_pc;
    logic [WORD_W-1:0] frame_index;
    logic [WORD_W-1:0] flags;
    logic [WORD_W-1:0] bc_pc;
  } entry_t;

endpackage

// ----- design/sorted_pc_side_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_pc_side_table_top
// Table of entries in native-pc order, held in one synchronous memory.
// Clear and append are handled in the idle state; the result is registered,
// shows on the next cycle, and a new command may start then. A pc lookup is a
// binary search with one memory read per step. An OSR lookup scans one entry
// per cycle until a hit or the end of the table. Reset empties the table and
// sets the OSR mask to 1; the memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_pc_side_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op_i,
  input  logic [sptab_pkg::WORD_W-1:0]  native_pc_i,
  input  logic [sptab_pkg::WORD_W-1:0]  frame_index_in_i,
  input  logic [sptab_pkg::WORD_W-1:0]  flags_in_i,
  input  logic [sptab_pkg::WORD_W-1:0]  bytecode_pc_in_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sptab_pkg::WORD_W-1:0]  cfg_data_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [sptab_pkg::IDX_W-1:0]   entry_index_o,
  output logic [sptab_pkg::WORD_W-1:0]  found_native_pc_o,
  output logic [sptab_pkg::WORD_W-1:0]  found_frame_index_o,
  output logic [sptab_pkg::WORD_W-1:0]  found_flags_o,
  output logic [sptab_pkg::WORD_W-1:0]  found_bytecode_pc_o
);
  import sptab_pkg::*;

  entry_t              mem_q [DEPTH];
  entry_t              rdata_q;
  logic                mem_we, mem_re;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  entry_t              wr_data;

  fsm_e                state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [WORD_W-1:0]   mask_q;
  logic [WORD_W-1:0]   last_pc_q, last_pc_d;
  logic [CNT_W-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, ptr_q, ptr_d;
  logic                pend_q, pend_d;
  logic [WORD_W-1:0]   target_q, target_d;
  logic [WORD_W-1:0]   bc_q, bc_d;
  entry_t              best_q, best_d;

  logic                out_valid_q, out_valid_d;
  status_e             status_q, status_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  entry_t              res_q, res_d;

  logic                accept;
  op_e                 op;
  logic                rd_le, osr_hit, bs_more, scan_more;
  logic [CNT_W-1:0]    lo_n, hi_n, mid_n, lo_m1;
  logic [CNT_W:0]      mid_sum;

  assign accept      = start && !busy;
  assign op          = op_e'(op_i);
  assign busy        = (state_q != FSM_IDLE);
  assign cfg_ready_o = 1'b1;

  // memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // search step
  always_comb begin
    rd_le     = (rdata_q.native_pc <= target_q);
    lo_n      = lo_q;
    hi_n      = hi_q;
    if (pend_q && rd_le) begin
      lo_n = mid_q + 1'b1;
    end else if (pend_q) begin
      hi_n = mid_q;
    end
    mid_sum   = {1'b0, lo_n} + {1'b0, hi_n};
    mid_n     = mid_sum[CNT_W:1];
    lo_m1     = lo_n - 1'b1;
    bs_more   = (lo_n < hi_n);
    osr_hit   = pend_q && ((rdata_q.flags & mask_q) != '0) &&
                (rdata_q.bc_pc == bc_q);
    scan_more = (ptr_q < count_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept && op == OP_LOOKUP_PC) begin
          state_d = FSM_BSEARCH;
        end else if (accept && op == OP_LOOKUP_OSR) begin
          state_d = FSM_SCAN;
        end
      end
      FSM_BSEARCH: begin
        if (!bs_more) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_SCAN: begin
        if (osr_hit || !scan_more) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    last_pc_d   = last_pc_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    target_d    = target_q;
    bc_d        = bc_q;
    best_d      = best_q;
    out_valid_d = 1'b0;
    status_d    = status_q;
    idx_d       = idx_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wr_addr     = count_q[IDX_W-1:0];
    rd_addr     = '0;
    wr_data     = '{native_pc: native_pc_i, frame_index: frame_index_in_i,
                    flags: flags_in_i, bc_pc: bytecode_pc_in_i};
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_CLEAR: begin
              count_d     = '0;
              out_valid_d = 1'b1;
              status_d    = ST_OK;
              idx_d       = '0;
              res_d       = '0;
            end
            OP_APPEND: begin
              out_valid_d = 1'b1;
              res_d       = '0;
              idx_d       = '0;
              if (count_q != '0 && native_pc_i < last_pc_q) begin
                status_d = ST_ORDER;
              end else if (count_q == CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                status_d  = ST_OK;
                idx_d     = count_q[IDX_W-1:0];
                mem_we    = 1'b1;
                count_d   = count_q + 1'b1;
                last_pc_d = native_pc_i;
              end
            end
            OP_LOOKUP_PC: begin
              lo_d     = '0;
              hi_d     = count_q;
              pend_d   = 1'b0;
              target_d = native_pc_i;
            end
            OP_LOOKUP_OSR: begin
              ptr_d  = '0;
              pend_d = 1'b0;
              bc_d   = bytecode_pc_in_i;
            end
            default: ;
          endcase
        end
      end
      FSM_BSEARCH: begin
        if (pend_q && rd_le) begin
          best_d = rdata_q;
        end
        lo_d = lo_n;
        hi_d = hi_n;
        if (bs_more) begin
          mem_re  = 1'b1;
          rd_addr = mid_n[IDX_W-1:0];
          mid_d   = mid_n;
          pend_d  = 1'b1;
        end else begin
          out_valid_d = 1'b1;
          pend_d      = 1'b0;
          if (lo_n == '0) begin
            status_d = ST_NONE;
            idx_d    = '0;
            res_d    = '0;
          end else begin
            status_d = ST_OK;
            idx_d    = lo_m1[IDX_W-1:0];
            res_d    = (pend_q && rd_le) ? rdata_q : best_q;
          end
        end
      end
      FSM_SCAN: begin
        if (osr_hit) begin
          out_valid_d = 1'b1;
          pend_d      = 1'b0;
          status_d    = ST_OK;
          idx_d       = mid_q[IDX_W-1:0];
          res_d       = rdata_q;
        end else if (scan_more) begin
          mem_re  = 1'b1;
          rd_addr = ptr_q[IDX_W-1:0];
          mid_d   = ptr_q;
          ptr_d   = ptr_q + 1'b1;
          pend_d  = 1'b1;
        end else begin
          out_valid_d = 1'b1;
          pend_d      = 1'b0;
          status_d    = ST_NONE;
          idx_d       = '0;
          res_d       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      mask_q      <= WORD_W'(1);
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mask_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_pc_q <= last_pc_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    ptr_q     <= ptr_d;
    target_q  <= target_d;
    bc_q      <= bc_d;
    best_q    <= best_d;
    status_q  <= status_d;
    idx_q     <= idx_d;
    res_q     <= res_d;
  end

  assign done_o              = out_valid_q;
  assign status_o            = status_q;
  assign entry_index_o       = idx_q;
  assign found_native_pc_o   = res_q.native_pc;
  assign found_frame_index_o = res_q.frame_index;
  assign found_flags_o       = res_q.flags;
  assign found_bytecode_pc_o = res_q.bc_pc;

endmodule

// ----- design/sptab_checker.sv -----
// ----------------------------------------------------------------------------
// sptab_checker
// Port-level checks for the sorted native-pc side table.
// ----------------------------------------------------------------------------
module sptab_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    op_i,
  input logic                          done_o,
  input logic [1:0]                    status_o,
  input logic [sptab_pkg::IDX_W-1:0]   entry_index_o,
  input logic [sptab_pkg::WORD_W-1:0]  found_native_pc_o
);
  import sptab_pkg::*;

  // clear and append answer on the next cycle
  a_short_cmd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_CLEAR || op_i == OP_APPEND)) |=> (done_o && !busy))
    else $error("clear/append result missing");

  // lookups hold the block busy
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_LOOKUP_PC || op_i == OP_LOOKUP_OSR)) |=> busy)
    else $error("lookup did not raise busy");

  // no result while a lookup runs; end of lookup gives exactly one result
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result during lookup");

  a_lookup_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("lookup ended without result");

  // failed transfers carry zeroed fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (entry_index_o == '0 && found_native_pc_o == '0))
    else $error("failed result has nonzero fields");

endmodule

bind sorted_pc_side_table_top sptab_checker u_sptab_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .op_i              (op_i),
  .done_o            (done_o),
  .status_o          (status_o),
  .entry_index_o     (entry_index_o),
  .found_native_pc_o (found_native_pc_o)
);
